// ----- rtl/zcp_pkg.sv -----
// Shared widths, constants, codes and types of the zero-cross phase meter.
package zcp_pkg;

  // Default width of the tick counters
  localparam int COUNT_BITS_DEF = 24;

  // Field widths
  localparam int D24_BITS  = 24;
  localparam int PER_BITS  = 25;
  localparam int PH_BITS   = 20;
  localparam int MDEG_BITS = 19;
  localparam int PROD_BITS = MDEG_BITS + D24_BITS;

  // Serial step counts: one delay bit per multiplier step, one quotient bit per divider step
  localparam int MUL_STEPS = D24_BITS;
  localparam int DIV_STEPS = PH_BITS;

  // Millidegrees in a full turn, and saturation values
  localparam logic [MDEG_BITS-1:0] MDEG_FULL = MDEG_BITS'(360000);
  localparam logic [PH_BITS-1:0]   PH_MAX    = '1;
  localparam logic [D24_BITS-1:0]  D24_MAX   = '1;

  // Register reset values
  localparam logic [PER_BITS-1:0] MIN_PERIOD_RST  = PER_BITS'(200);
  localparam logic [PH_BITS-1:0]  PHASE_LIMIT_RST = PH_BITS'(180000);

  // Register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_PERIOD  = 2'd0,
    CFG_PHASE_LIMIT = 2'd1
  } cfg_index_t;

  // Measured period and delay of one measurement
  typedef struct packed {
    logic [PER_BITS-1:0] per;
    logic [D24_BITS-1:0] dly;
  } meas_t;

endpackage

// ----- rtl/zero_cross_phase_meter.sv -----
// Top level of the zero-cross phase meter: sequencer, serial multiplier, divider, output word.
// Each input word is one timer tick carrying the reference and test comparator levels. A tick
// that produces no result is taken without a stall. The tick that completes a measurement (the
// test rising edge) starts the phase calculation, and in_ready stays low through it: one
// sequencer register, 24 steps of the bit-serial multiply by 360000, a handoff and 20 steps
// of the restoring divider (fewer when the phase saturates). The finished word waits in the
// divider until the output register is free, and ticks are taken again once it is loaded there.
// Configuration writes are taken in any cycle; cfg_ready is always high.
module zero_cross_phase_meter
  import zcp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    ref_level,
  input  logic                    test_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PER_BITS-1:0]     period_ticks,
  output logic [D24_BITS-1:0]     delay_ticks,
  output logic [PH_BITS-1:0]      phase_mdeg,
  output logic                    period_ok,
  output logic                    phase_ok,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PER_BITS-1:0]     cfg_data
);

  logic [PER_BITS-1:0]  min_period_ticks;
  logic [PH_BITS-1:0]   phase_limit_mdeg;
  logic                 tick;
  logic                 seq_start;
  meas_t                meas;
  logic                 mul_busy, mul_done;
  logic [PROD_BITS-1:0] prod;
  logic                 div_busy, div_valid;
  logic [PH_BITS-1:0]   div_quo;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = !(seq_start || mul_busy || mul_done || div_busy);
  assign tick      = in_valid && in_ready;
  assign out_load  = div_valid && (!out_valid || out_ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period_ticks <= MIN_PERIOD_RST;
      phase_limit_mdeg <= PHASE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_PERIOD:  min_period_ticks <= cfg_data;
        CFG_PHASE_LIMIT: phase_limit_mdeg <= cfg_data[PH_BITS-1:0];
        default: ;
      endcase
    end
  end

  zcp_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .ref_level  (ref_level),
    .test_level (test_level),
    .start      (seq_start),
    .meas       (meas)
  );

  zcp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (seq_start),
    .dly   (meas.dly),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  zcp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done),
    .num   (prod),
    .per   (meas.per),
    .take  (out_load),
    .busy  (div_busy),
    .valid (div_valid),
    .quo   (div_quo)
  );

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output word and its flags
  always_ff @(posedge clk) begin
    if (out_load) begin
      period_ticks <= meas.per;
      delay_ticks  <= meas.dly;
      phase_mdeg   <= div_quo;
      period_ok    <= meas.per > min_period_ticks;
      phase_ok     <= (div_quo < phase_limit_mdeg) && (meas.per != '0);
    end
  end

  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_ticks == '0) |-> (phase_mdeg == PH_MAX && !phase_ok))
    else $error("zero period without saturated phase");

  a_period_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_ok) |-> (period_ticks != '0))
    else $error("period flagged valid at zero");

  a_seq_to_mul: assert property (@(posedge clk) disable iff (rst)
    seq_start |=> mul_busy)
    else $error("multiplier did not start after measurement");

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    mul_done |=> div_busy)
    else $error("divider did not start after multiply");

endmodule

// ----- rtl/zcp_seq.sv -----
// Tick sequencer: edge tracking and saturating half-period and delay counters.
module zcp_seq
  import zcp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  tick,
  input  logic  ref_level,
  input  logic  test_level,
  output logic  start,
  output meas_t meas
);

  typedef enum logic [5:0] {
    ST_REF_LOW   = 6'b000001,
    ST_REF_RISE  = 6'b000010,
    ST_HALF      = 6'b000100,
    ST_SYNC      = 6'b001000,
    ST_TEST_LOW  = 6'b010000,
    ST_TEST_HIGH = 6'b100000
  } seq_state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  seq_state_t state, state_next;
  logic [COUNT_BITS-1:0] half_count, half_count_next, half_inc;
  logic [COUNT_BITS-1:0] delay_count, delay_count_next, delay_inc;
  logic [D24_BITS-1:0] half_sat, dly_sat;
  logic emit;
  meas_t meas_next;

  // Saturating increments
  assign half_inc  = (half_count == CNT_MAX) ? CNT_MAX : half_count + 1'b1;
  assign delay_inc = (delay_count == CNT_MAX) ? CNT_MAX : delay_count + 1'b1;

  // Step through the edges of one measurement
  always_comb begin
    state_next       = state;
    half_count_next  = half_count;
    delay_count_next = delay_count;
    emit             = 1'b0;
    case (state)
      ST_REF_RISE: begin
        if (ref_level) begin
          half_count_next = '0;
          state_next      = ST_HALF;
        end
      end
      ST_HALF: begin
        half_count_next = half_inc;
        if (!ref_level) state_next = ST_SYNC;
      end
      ST_SYNC: begin
        if (ref_level) begin
          delay_count_next = '0;
          state_next       = test_level ? ST_TEST_LOW : ST_TEST_HIGH;
        end
      end
      ST_TEST_LOW: begin
        delay_count_next = delay_inc;
        if (!test_level) state_next = ST_TEST_HIGH;
      end
      ST_TEST_HIGH: begin
        delay_count_next = delay_inc;
        if (test_level) begin
          emit       = tick;
          state_next = ST_REF_LOW;
        end
      end
      default: begin
        state_next = ref_level ? ST_REF_LOW : ST_REF_RISE;
      end
    endcase
  end

  // Clamp both counts to 24 bits for reporting
  assign half_sat = ((half_count >> D24_BITS) != '0) ? D24_MAX : D24_BITS'(half_count);
  assign dly_sat  = ((delay_inc >> D24_BITS) != '0) ? D24_MAX : D24_BITS'(delay_inc);

  always_comb begin
    meas_next.per = {half_sat, 1'b0};
    meas_next.dly = dly_sat;
  end

  // Advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_REF_LOW;
      half_count  <= '0;
      delay_count <= '0;
      start       <= 1'b0;
    end else begin
      start <= emit;
      if (tick) begin
        state       <= state_next;
        half_count  <= half_count_next;
        delay_count <= delay_count_next;
      end
    end
  end

  // Hold the measurement until the next one
  always_ff @(posedge clk) begin
    if (emit) meas <= meas_next;
  end

endmodule

// ----- rtl/zcp_mul.sv -----
// Bit-serial multiplier of the delay by the millidegrees of a full turn.
module zcp_mul
  import zcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [D24_BITS-1:0]  dly,
  output logic                 busy,
  output logic                 done,
  output logic [PROD_BITS-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic [CNT_W-1:0]    cnt;
  logic [D24_BITS-1:0] shreg;
  logic [PROD_BITS-1:0] addend;

  // Add the constant for each delay bit, most significant first
  assign addend = shreg[D24_BITS-1] ? PROD_BITS'(MDEG_FULL) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the multiplier and accumulate the product
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dly;
      prod  <= '0;
    end else if (busy) begin
      shreg <= {shreg[D24_BITS-2:0], 1'b0};
      prod  <= {prod[PROD_BITS-2:0], 1'b0} + addend;
    end
  end

endmodule

// ----- rtl/zcp_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating at the phase maximum.
module zcp_div
  import zcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PROD_BITS-1:0] num,
  input  logic [PER_BITS-1:0]  per,
  input  logic                 take,
  output logic                 busy,
  output logic                 valid,
  output logic [PH_BITS-1:0]   quo
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int HI_W  = PROD_BITS - PH_BITS;

  logic [CNT_W-1:0]    cnt;
  logic                run;
  logic                sat;
  logic [PER_BITS-1:0] rem;
  logic [PH_BITS-1:0]  lo;
  logic [PER_BITS:0]   trial;
  logic [PER_BITS+1:0] diff;
  logic                ge;

  // Quotient overflows the phase field when the top of the dividend reaches the period, or the period is zero
  assign sat = (per == '0) || (PER_BITS'(num[PROD_BITS-1:PH_BITS]) >= per);

  // Trial subtract of the shifted remainder
  assign trial = {rem, lo[PH_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, per};
  assign ge    = !diff[PER_BITS+1];

  assign busy = run | valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else begin
      if (start) begin
        cnt <= '0;
        if (sat) valid <= 1'b1;
        else     run   <= 1'b1;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          run   <= 1'b0;
          valid <= 1'b1;
        end
      end else if (take) begin
        valid <= 1'b0;
      end
    end
  end

  // Shift in dividend bits and build the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= PER_BITS'(num[PROD_BITS-1:PH_BITS]);
      lo  <= num[PH_BITS-1:0];
      quo <= sat ? PH_MAX : '0;
    end else if (run) begin
      rem <= ge ? diff[PER_BITS-1:0] : trial[PER_BITS-1:0];
      lo  <= {lo[PH_BITS-2:0], 1'b0};
      quo <= {quo[PH_BITS-2:0], ge};
    end
  end

  // Upper dividend part is narrower than the remainder register
  if (HI_W > PER_BITS) begin : g_width_check
    $error("dividend top wider than remainder");
  end

endmodule
